### rtl/c2d_pkg.sv
// shared types and constants for the 2-d convolution block
package c2d_pkg;

   localparam logic [1:0] OP_SAMPLE = 2'd0;
   localparam logic [1:0] OP_WEIGHT = 2'd1;
   localparam logic [1:0] OP_BIAS   = 2'd2;

   localparam logic [2:0] REG_KW = 3'd0;
   localparam logic [2:0] REG_KH = 3'd1;
   localparam logic [2:0] REG_NK = 3'd2;
   localparam logic [2:0] REG_NC = 3'd3;
   localparam logic [2:0] REG_IW = 3'd4;
   localparam logic [2:0] REG_IH = 3'd5;

   localparam int RES_W = 40;
   localparam int ACC_W = 48;

   // controller to datapath
   typedef struct packed {
      logic clear;      // start a new kernel sum
      logic mac;        // accumulate the registered weight-sample product
      logic finish;     // subtract bias, saturate, load the output register
   } c2d_cmd_type;

endpackage

### rtl/conv2d_forward_mac.sv
// Streaming valid 2-d convolution (stride 1, multichannel) with one shared MAC.
// Weight and bias writes and samples arrive on the req channel; the block takes
// samples back to back until one completes a window, after which the block
// runs the mac sequence of each kernel in turn on its single multiplier
// and weight-store read port, also stalling while a finished kernel sum
// waits for the previous result to leave the output register, before taking
// the next item. A result waiting in the output register does not by itself
// hold off the input. Results leave one per kernel, last set on the final kernel.
module conv2d_forward_mac
   import c2d_pkg::*;
#(
   parameter int MAX_KERNELS      = 16,
   parameter int MAX_KERNEL_SIDE  = 8,
   parameter int MAX_CHANNELS     = 16,
   parameter int MAX_IMAGE_WIDTH  = 256,
   parameter int MAX_IMAGE_HEIGHT = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [8:0]  csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // value[15:0], weight_slot[29:16], bias_slot[33:30]
   input  logic [1:0]  req_tuser,  // operation[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,  // result[39:0], out_row[47:40], out_col[55:48]
   output logic [3:0]  rsp_tuser,  // kernel_number[3:0]
   output logic        rsp_tlast
);
   localparam int LINE_DEPTH = MAX_KERNEL_SIDE * MAX_IMAGE_WIDTH * MAX_CHANNELS;
   localparam int WDEPTH = MAX_KERNELS * MAX_KERNEL_SIDE * MAX_KERNEL_SIDE * MAX_CHANNELS;
   localparam int LINE_AW = $clog2(LINE_DEPTH);
   localparam int WEIGHT_AW = $clog2(WDEPTH);

   c2d_cmd_type cmd;
   logic line_we, weight_we, bias_we;
   logic [LINE_AW-1:0] line_waddr, line_raddr;
   logic [WEIGHT_AW-1:0] weight_waddr, weight_raddr;
   logic [3:0] bias_waddr, bias_raddr;
   logic [15:0] line_q, weight_q, bias_q;
   logic [RES_W-1:0] result;
   logic [7:0] row, col;

   c2d_ctrl #(
      .MAX_KERNELS(MAX_KERNELS), .MAX_KERNEL_SIDE(MAX_KERNEL_SIDE),
      .MAX_CHANNELS(MAX_CHANNELS), .MAX_IMAGE_WIDTH(MAX_IMAGE_WIDTH),
      .MAX_IMAGE_HEIGHT(MAX_IMAGE_HEIGHT), .LINE_AW(LINE_AW), .WEIGHT_AW(WEIGHT_AW)
   ) u_ctrl (
      .clock, .reset, .csr_we, .csr_index, .csr_wdata,
      .req_tvalid, .req_tready, .req_op(req_tuser),
      .req_wslot(req_tdata[29:16]), .req_bslot(req_tdata[33:30]),
      .line_we, .line_waddr, .line_raddr, .weight_we, .weight_waddr, .weight_raddr,
      .bias_we, .bias_waddr, .bias_raddr, .cmd,
      .rsp_tvalid, .rsp_tready, .rsp_row(row), .rsp_col(col),
      .rsp_kernel(rsp_tuser), .rsp_last(rsp_tlast)
   );

   c2d_ram #(.WIDTH(16), .DEPTH(LINE_DEPTH)) u_line (
      .clock, .wr_en(line_we), .wr_addr(line_waddr), .wr_data(req_tdata[15:0]),
      .rd_addr(line_raddr), .rd_data(line_q)
   );

   c2d_ram #(.WIDTH(16), .DEPTH(WDEPTH)) u_weight (
      .clock, .wr_en(weight_we), .wr_addr(weight_waddr), .wr_data(req_tdata[15:0]),
      .rd_addr(weight_raddr), .rd_data(weight_q)
   );

   c2d_ram #(.WIDTH(16), .DEPTH(16)) u_bias (
      .clock, .wr_en(bias_we), .wr_addr(bias_waddr), .wr_data(req_tdata[15:0]),
      .rd_addr(bias_raddr), .rd_data(bias_q)
   );

   c2d_datapath u_dp (
      .clock, .cmd, .weight(weight_q), .sample(line_q),
      .bias(bias_q), .result
   );

   assign rsp_tdata = {col, row, result};
endmodule

### rtl/c2d_ram.sv
// generic single-port-write, single-port-read ram with registered read
module c2d_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

### rtl/c2d_datapath.sv
// multiply-accumulate datapath with bias subtract and saturation
module c2d_datapath
   import c2d_pkg::*;
(
   input  logic                    clock,
   input  c2d_cmd_type             cmd,
   input  logic signed [15:0]      weight,
   input  logic signed [15:0]      sample,
   input  logic signed [15:0]      bias,
   output logic signed [RES_W-1:0] result
);
   logic signed [31:0]      prod_ff, prod_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [RES_W-1:0] result_ff, result_in;
   logic signed [ACC_W-1:0] diff;

   localparam logic signed [ACC_W-1:0] RMAX = ACC_W'(64'sd549755813887);
   localparam logic signed [ACC_W-1:0] RMIN = -RMAX - ACC_W'(1);

   always_comb begin
      prod_in = weight * sample;
      acc_in = acc_ff;
      if (cmd.clear) begin
         acc_in = '0;
      end else if (cmd.mac) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end
      diff = acc_ff - (ACC_W'(bias) <<< 8);
      result_in = result_ff;
      if (cmd.finish) begin
         if (diff > RMAX) begin
            result_in = RMAX[RES_W-1:0];
         end else if (diff < RMIN) begin
            result_in = RMIN[RES_W-1:0];
         end else begin
            result_in = diff[RES_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      acc_ff    <= acc_in;
      result_ff <= result_in;
   end

   assign result = result_ff;
endmodule

### rtl/c2d_ctrl.sv
// controller: positions, store addressing and the per-window mac sequence
module c2d_ctrl
   import c2d_pkg::*;
#(
   parameter int MAX_KERNELS      = 16,
   parameter int MAX_KERNEL_SIDE  = 8,
   parameter int MAX_CHANNELS     = 16,
   parameter int MAX_IMAGE_WIDTH  = 256,
   parameter int MAX_IMAGE_HEIGHT = 256,
   parameter int LINE_AW          = 15,
   parameter int WEIGHT_AW        = 14
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [2:0]           csr_index,
   input  logic [8:0]           csr_wdata,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [1:0]           req_op,
   input  logic [13:0]          req_wslot,
   input  logic [3:0]           req_bslot,
   output logic                 line_we,
   output logic [LINE_AW-1:0]   line_waddr,
   output logic [LINE_AW-1:0]   line_raddr,
   output logic                 weight_we,
   output logic [WEIGHT_AW-1:0] weight_waddr,
   output logic [WEIGHT_AW-1:0] weight_raddr,
   output logic                 bias_we,
   output logic [3:0]           bias_waddr,
   output logic [3:0]           bias_raddr,
   output c2d_cmd_type          cmd,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [7:0]           rsp_row,
   output logic [7:0]           rsp_col,
   output logic [3:0]           rsp_kernel,
   output logic                 rsp_last
);
   localparam int SW  = $clog2(MAX_KERNEL_SIDE + 1);
   localparam int KW  = $clog2(MAX_KERNELS + 1);
   localparam int CW  = $clog2(MAX_CHANNELS + 1);
   localparam int XW  = $clog2(MAX_IMAGE_WIDTH + 1);
   localparam int YW  = $clog2(MAX_IMAGE_HEIGHT + 1);
   localparam int LRW = (MAX_KERNEL_SIDE > 1) ? $clog2(MAX_KERNEL_SIDE) : 1;
   localparam int LXW = (MAX_IMAGE_WIDTH > 1) ? $clog2(MAX_IMAGE_WIDTH) : 1;
   localparam int LCW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_RUN  = 3'd1;
   localparam logic [2:0] ST_WAIT = 3'd2;
   localparam logic [2:0] ST_FIN  = 3'd3;
   localparam logic [2:0] ST_OUT  = 3'd4;

   logic [3:0] kw_reg_ff, kh_reg_ff;
   logic [4:0] nk_reg_ff, nc_reg_ff;
   logic [8:0] iw_reg_ff, ih_reg_ff;
   logic [SW-1:0] kw, kh;
   logic [KW-1:0] nk;
   logic [CW-1:0] nc;
   logic [XW-1:0] iw;
   logic [YW-1:0] ih;

   logic [2:0]    state_ff, state_in;
   logic [YW-1:0] row_ff, row_in;
   logic [XW-1:0] col_ff, col_in;
   logic [CW-1:0] ch_ff, ch_in;
   logic [YW-1:0] top_ff, top_in;
   logic [XW-1:0] left_ff, left_in;
   logic [KW-1:0] k_ff, k_in;
   logic [SW-1:0] r_ff, r_in, c_ff, c_in;
   logic [CW-1:0] cc_ff, cc_in;
   logic [WEIGHT_AW:0] wa_ff, wa_in;
   logic [1:0] pipe_ff, pipe_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic acc_sample, wrap, window_done, iter_last, issue;
   logic [YW-1:0] rowu;
   logic [XW-1:0] colu;
   logic [CW-1:0] chu;
   logic [YW:0]   lrow_full;
   logic [XW-1:0] lcol;

   function automatic logic [8:0] clampv(input logic [8:0] v, input int hi);
      logic [8:0] r;
      r = v;
      if (v == 9'd0) begin
         r = 9'd1;
      end else if (32'(v) > hi) begin
         r = 9'(hi);
      end
      return r;
   endfunction

   assign kw = SW'(clampv({5'd0, kw_reg_ff}, MAX_KERNEL_SIDE));
   assign kh = SW'(clampv({5'd0, kh_reg_ff}, MAX_KERNEL_SIDE));
   assign nk = KW'(clampv({4'd0, nk_reg_ff}, MAX_KERNELS));
   assign nc = CW'(clampv({4'd0, nc_reg_ff}, MAX_CHANNELS));
   assign iw = XW'(clampv(iw_reg_ff, MAX_IMAGE_WIDTH));
   assign ih = YW'(clampv(ih_reg_ff, MAX_IMAGE_HEIGHT));

   always_ff @(posedge clock) begin
      if (reset) begin
         kw_reg_ff <= 4'd3;
         kh_reg_ff <= 4'd3;
         nk_reg_ff <= 5'd1;
         nc_reg_ff <= 5'd1;
         iw_reg_ff <= 9'd32;
         ih_reg_ff <= 9'd32;
      end else if (csr_we) begin
         case (csr_index)
            REG_KW:  kw_reg_ff <= csr_wdata[3:0];
            REG_KH:  kh_reg_ff <= csr_wdata[3:0];
            REG_NK:  nk_reg_ff <= csr_wdata[4:0];
            REG_NC:  nc_reg_ff <= csr_wdata[4:0];
            REG_IW:  iw_reg_ff <= csr_wdata;
            REG_IH:  ih_reg_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // out-of-bounds positions restart the image
   assign wrap = (row_ff >= ih) || (col_ff >= iw) || (ch_ff >= nc);
   assign rowu = wrap ? '0 : row_ff;
   assign colu = wrap ? '0 : col_ff;
   assign chu  = wrap ? '0 : ch_ff;

   // a result waiting in the output register does not hold off the input
   assign req_tready = (state_ff == ST_IDLE);
   assign acc_sample = req_tvalid && req_tready && (req_op == OP_SAMPLE);
   assign window_done = (32'(chu) + 1 >= 32'(nc)) && (32'(rowu) + 1 >= 32'(kh))
                        && (32'(colu) + 1 >= 32'(kw));

   assign line_we    = acc_sample;
   assign line_waddr = LINE_AW'({rowu[LRW-1:0], colu[LXW-1:0], chu[LCW-1:0]});
   assign weight_we  = req_tvalid && req_tready && (req_op == OP_WEIGHT)
                       && (32'(req_wslot) < (1 << WEIGHT_AW));
   assign weight_waddr = WEIGHT_AW'(req_wslot);
   assign bias_we    = req_tvalid && req_tready && (req_op == OP_BIAS)
                       && (32'(req_bslot) < MAX_KERNELS);
   assign bias_waddr = req_bslot;
   assign bias_raddr = 4'(k_ff);

   assign lrow_full  = (YW + 1)'(top_ff) + (YW + 1)'(r_ff);
   assign lcol       = left_ff + XW'(c_ff);
   assign line_raddr = LINE_AW'({lrow_full[LRW-1:0], lcol[LXW-1:0], cc_ff[LCW-1:0]});
   assign weight_raddr = wa_ff[WEIGHT_AW-1:0];

   assign issue = (state_ff == ST_RUN);
   assign iter_last = (cc_ff + 1 == nc) && (c_ff + 1 == kw) && (r_ff + 1 == kh);

   always_comb begin
      state_in = state_ff;
      row_in = row_ff; col_in = col_ff; ch_in = ch_ff;
      top_in = top_ff; left_in = left_ff;
      k_in = k_ff; r_in = r_ff; c_in = c_ff; cc_in = cc_ff;
      wa_in = wa_ff;
      pipe_in = {pipe_ff[0], issue};
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd = '0;
      cmd.mac = pipe_ff[1];
      case (state_ff)
         ST_IDLE: begin
            if (acc_sample) begin
               row_in = rowu; col_in = colu; ch_in = chu;
               if (32'(chu) + 1 < 32'(nc)) begin
                  ch_in = chu + 1'b1;
               end else begin
                  ch_in = '0;
                  if (32'(colu) + 1 >= 32'(iw)) begin
                     col_in = '0;
                     row_in = (32'(rowu) + 1 >= 32'(ih)) ? '0 : rowu + 1'b1;
                  end else begin
                     col_in = colu + 1'b1;
                  end
                  if (window_done) begin
                     top_in  = YW'(rowu + 1'b1 - YW'(kh));
                     left_in = XW'(colu + 1'b1 - XW'(kw));
                     k_in = '0; r_in = '0; c_in = '0; cc_in = '0;
                     wa_in = '0;
                     cmd.clear = 1'b1;
                     state_in = ST_RUN;
                  end
               end
            end
         end
         ST_RUN: begin
            // weight slots are contiguous per kernel in r, c, channel order
            wa_in = wa_ff + 1'b1;
            if (cc_ff + 1 != nc) begin
               cc_in = cc_ff + 1'b1;
            end else begin
               cc_in = '0;
               if (c_ff + 1 != kw) begin
                  c_in = c_ff + 1'b1;
               end else begin
                  c_in = '0;
                  r_in = r_ff + 1'b1;
               end
            end
            if (iter_last) begin
               r_in = '0;
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (!pipe_ff[0] && !pipe_ff[1]) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff) begin
               cmd.finish = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // result register loaded; start the next kernel, if any, while it waits
            cmd.clear = 1'b1;
            if (k_ff + 1 == nk) begin
               state_in = ST_IDLE;
            end else begin
               k_in = k_ff + 1'b1;
               state_in = ST_RUN;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      // unknown register indexes leave the positions alone
      if (csr_we && (csr_index inside {[REG_KW:REG_IH]})) begin
         row_in = '0; col_in = '0; ch_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         row_ff <= '0; col_ff <= '0; ch_ff <= '0;
         pipe_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         row_ff <= row_in; col_ff <= col_in; ch_ff <= ch_in;
         pipe_ff <= pipe_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff <= top_in; left_ff <= left_in;
      k_ff <= k_in; r_ff <= r_in; c_ff <= c_in; cc_ff <= cc_in;
      wa_ff <= wa_in;
      if (cmd.finish) begin
         rsp_row    <= 8'(top_ff);
         rsp_col    <= 8'(left_ff);
         rsp_kernel <= 4'(k_ff);
         rsp_last   <= (k_ff + 1 == nk);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_tready)
      else $error("input taken during window");
   a_finish_idle_out: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !rsp_valid_ff)
      else $error("result register overwritten");
   a_mac_after_run: assert property (@(posedge clock) disable iff (reset)
      cmd.mac |-> $past(state_ff == ST_RUN, 2))
      else $error("mac without issue");
endmodule

### test/tb_top.sv
// self-checking testbench for the streaming 2-d convolution block
`timescale 1ns / 1ps

module tb_top;
   import c2d_pkg::*;

   localparam logic [1:0] OP_NONE = 2'd3;
   localparam logic [2:0] REG_BAD = 3'd6;
   localparam int CYCLE_LIMIT = 100000;

   typedef struct {
      logic signed [39:0] sum;
      logic [7:0]         row;
      logic [7:0]         col;
      logic [3:0]         kern;
      logic               last;
   } window_sum_type;

   typedef struct {
      logic [1:0]         op;
      logic [15:0]        val;
      logic [13:0]        wslot;
      logic [3:0]         bslot;
      bit                 typed;
      longint             sum;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [8:0]  csr_wdata;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;   // value[15:0], weight_slot[29:16], bias_slot[33:30]
   logic [1:0]  req_tuser;   // operation[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [55:0] rsp_tdata;   // result[39:0], out_row[47:40], out_col[55:48]
   logic [3:0]  rsp_tuser;   // kernel_number[3:0]
   logic        rsp_tlast;

   conv2d_forward_mac uut (.*);

   // predictor state
   logic signed [15:0] line_mem [32768];
   logic signed [15:0] weight_mem [16384];
   logic signed [15:0] bias_mem [16];
   logic [8:0]         reg_raw [6];
   int                 row_pos, col_pos, chan_pos;

   window_sum_type sums_pending[$];
   stim_row_type   dir_tab[12];
   int          fail_count;
   int          items_sent;
   int          sums_seen;
   int          windows_sat;
   int          cycle_count;
   int          hold_cycles;
   bit          no_idle;

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic int clampv(logic [8:0] v, int hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return int'(v);
   endfunction

   function automatic void predict_sample(logic signed [15:0] v, bit typed, longint tsum);
      int kw, kh, nk, nc, iw, ih, top, left, lrow, lbase, wbase;
      longint acc;
      window_sum_type e;
      kw = clampv(reg_raw[REG_KW], 8);
      kh = clampv(reg_raw[REG_KH], 8);
      nk = clampv(reg_raw[REG_NK], 16);
      nc = clampv(reg_raw[REG_NC], 16);
      iw = clampv(reg_raw[REG_IW], 256);
      ih = clampv(reg_raw[REG_IH], 256);
      if (row_pos >= ih || col_pos >= iw || chan_pos >= nc) begin
         row_pos = 0;
         col_pos = 0;
         chan_pos = 0;
      end
      line_mem[((row_pos % 8) * 256 + col_pos) * 16 + chan_pos] = v;
      if (chan_pos + 1 < nc) begin
         chan_pos++;
         return;
      end
      if (row_pos + 1 >= kh && col_pos + 1 >= kw) begin
         top = row_pos + 1 - kh;
         left = col_pos + 1 - kw;
         for (int k = 0; k < nk; k++) begin
            acc = 0;
            for (int r = 0; r < kh; r++) begin
               lrow = (top + r) % 8;
               for (int c = 0; c < kw; c++) begin
                  lbase = (lrow * 256 + left + c) * 16;
                  wbase = ((k * kh + r) * kw + c) * nc;
                  for (int ch = 0; ch < nc; ch++)
                     acc += longint'(weight_mem[wbase + ch]) * longint'(line_mem[lbase + ch]);
               end
            end
            acc -= longint'(bias_mem[k]) * 256;
            if (acc > 64'sd549755813887 || acc < -64'sd549755813888) windows_sat++;
            if (acc > 64'sd549755813887) acc = 64'sd549755813887;
            if (acc < -64'sd549755813888) acc = -64'sd549755813888;
            e.sum = (typed && k == 0) ? tsum[39:0] : acc[39:0];
            e.row = top[7:0];
            e.col = left[7:0];
            e.kern = k[3:0];
            e.last = (k + 1 == nk);
            sums_pending.push_back(e);
         end
      end
      chan_pos = 0;
      col_pos++;
      if (col_pos >= iw) begin
         col_pos = 0;
         row_pos++;
         if (row_pos >= ih) row_pos = 0;
      end
   endfunction

   task automatic send_item(logic [1:0] op, logic [15:0] val, logic [13:0] wslot,
                            logic [3:0] bslot, bit typed, longint tsum);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata <= {6'd0, bslot, wslot, val};
      req_tuser <= op;
      do @(posedge clock); while (!req_tready);
      items_sent++;
      case (op)
         OP_WEIGHT: weight_mem[wslot] = val;
         OP_BIAS:   bias_mem[bslot] = val;
         OP_SAMPLE: predict_sample(val, typed, tsum);
         default: ;
      endcase
      gap = no_idle ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // quiet the input, let all results drain, then allow for the last window's tail
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sums_pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_regs(logic [8:0] kw, logic [8:0] kh, logic [8:0] nk,
                             logic [8:0] nc, logic [8:0] iw, logic [8:0] ih);
      logic [8:0] vals [6];
      logic [8:0] masks [6];
      vals = '{kw, kh, nk, nc, iw, ih};
      masks = '{9'h00f, 9'h00f, 9'h01f, 9'h01f, 9'h1ff, 9'h1ff};
      // an unknown index must change nothing
      csr_we <= 1'b1;
      csr_index <= REG_BAD;
      csr_wdata <= 9'h1ff;
      @(posedge clock);
      for (int i = 0; i < 6; i++) begin
         csr_index <= i[2:0];
         csr_wdata <= vals[i];
         @(posedge clock);
         reg_raw[i] = vals[i] & masks[i];
      end
      csr_we <= 1'b0;
      row_pos = 0;
      col_pos = 0;
      chan_pos = 0;
   endtask

   function automatic logic [15:0] rand_value();
      case ($urandom_range(0, 7))
         0: return 16'h8000;
         1: return 16'h7fff;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic run_image(logic [8:0] kw, logic [8:0] kh, logic [8:0] nk, logic [8:0] nc,
                            logic [8:0] iw, logic [8:0] ih, int samples);
      int nslots, per_kern;
      drain();
      write_regs(kw, kh, nk, nc, iw, ih);
      per_kern = clampv(reg_raw[REG_KW], 8) * clampv(reg_raw[REG_KH], 8)
                 * clampv(reg_raw[REG_NC], 16);
      nslots = per_kern * clampv(reg_raw[REG_NK], 16);
      send_item(OP_NONE, 16'($urandom), 14'($urandom), 4'($urandom), 0, 0);
      send_item(OP_WEIGHT, 16'($urandom), 14'($urandom), 4'd0, 0, 0);
      send_item(OP_BIAS, 16'($urandom), 14'd0, 4'($urandom), 0, 0);
      for (int s = 0; s < nslots; s++)
         send_item(OP_WEIGHT, rand_value(), s[13:0], 4'd0, 0, 0);
      for (int k = 0; k < clampv(reg_raw[REG_NK], 16); k++)
         send_item(OP_BIAS, rand_value(), 14'd0, k[3:0], 0, 0);
      for (int s = 0; s < samples; s++)
         send_item(OP_SAMPLE, rand_value(), 14'($urandom), 4'($urandom), 0, 0);
   endtask

   // result side
   initial begin
      int stall;
      window_sum_type e;
      rsp_tready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 19);
         if (hold_cycles > 0) begin
            stall = hold_cycles;
            hold_cycles = 0;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         sums_seen++;
         if (sums_pending.size() == 0) begin
            $error("result transfer with nothing expected: %0d", $signed(rsp_tdata[39:0]));
            fail_count++;
         end else begin
            e = sums_pending.pop_front();
            if (rsp_tdata[39:0] !== e.sum) begin
               $error("result expected %0d actual %0d", e.sum, $signed(rsp_tdata[39:0]));
               fail_count++;
            end
            if (rsp_tdata[47:40] !== e.row) begin
               $error("out_row expected %0d actual %0d", e.row, rsp_tdata[47:40]);
               fail_count++;
            end
            if (rsp_tdata[55:48] !== e.col) begin
               $error("out_col expected %0d actual %0d", e.col, rsp_tdata[55:48]);
               fail_count++;
            end
            if (rsp_tuser !== e.kern) begin
               $error("kernel_number expected %0d actual %0d", e.kern, rsp_tuser);
               fail_count++;
            end
            if (rsp_tlast !== e.last) begin
               $error("last expected %0d actual %0d", e.last, rsp_tlast);
               fail_count++;
            end
         end
      end
   end

   initial begin
      int iw, ih, nc, kw, kh;
      cycle_count = 0;
      fail_count = 0;
      items_sent = 0;
      sums_seen = 0;
      windows_sat = 0;
      hold_cycles = 0;
      no_idle = 0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      reg_raw = '{9'd3, 9'd3, 9'd1, 9'd1, 9'd32, 9'd32};
      row_pos = 0;
      col_pos = 0;
      chan_pos = 0;
      dir_tab = '{
         '{OP_WEIGHT, 16'h7fff, 14'd0,     4'd0,  0, 0},
         '{OP_BIAS,   16'h8000, 14'd0,     4'd0,  0, 0},
         '{OP_NONE,   16'h1234, 14'h3fff,  4'hf,  0, 0},
         '{OP_SAMPLE, 16'h7fff, 14'd0,     4'd0,  1, 64'sd1082064897},
         '{OP_SAMPLE, 16'h8000, 14'd0,     4'd0,  1, -64'sd1065320448},
         '{OP_WEIGHT, 16'h8000, 14'd0,     4'd0,  0, 0},
         '{OP_BIAS,   16'h7fff, 14'd0,     4'd0,  0, 0},
         '{OP_WEIGHT, 16'h5a5a, 14'h3fff,  4'd0,  0, 0},
         '{OP_BIAS,   16'ha5a5, 14'd0,     4'hf,  0, 0},
         '{OP_SAMPLE, 16'h0000, 14'd0,     4'd0,  1, -64'sd8388352},
         '{OP_SAMPLE, 16'h7fff, 14'h2aaa,  4'h5,  0, 0},
         '{OP_SAMPLE, 16'h0100, 14'h1555,  4'ha,  0, 0}
      };
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // 1x1 kernel on a 2x2 image: every sample is a window
      write_regs(9'd1, 9'd1, 9'd1, 9'd1, 9'd2, 9'd2);
      foreach (dir_tab[i])
         send_item(dir_tab[i].op, dir_tab[i].val, dir_tab[i].wslot, dir_tab[i].bslot,
                   dir_tab[i].typed, dir_tab[i].sum);

      // image narrower than the kernel: nothing comes out
      run_image(9'd3, 9'd1, 9'd1, 9'd1, 9'd2, 9'd2, 3);
      // out-of-range register values clamp: 1x1 kernel, 16 kernels, 256-wide single row
      run_image(9'd0, 9'd0, 9'd31, 9'd0, 9'd511, 9'd0, 2);

      // receiver holds off while samples keep coming, so the block backs up
      drain();
      hold_cycles = 600;
      run_image(9'd2, 9'd2, 9'd2, 9'd1, 9'd3, 9'd2, 9);

      for (int p = 0; p < 2; p++) begin
         kw = $urandom_range(1, 2);
         kh = $urandom_range(1, 2);
         nc = $urandom_range(1, 2);
         iw = kw + $urandom_range(0, 1);
         ih = kh;
         no_idle = (p == 1);
         run_image(kw[8:0], kh[8:0], 9'($urandom_range(1, 2)), nc[8:0], iw[8:0], ih[8:0],
                   iw * ih * nc + $urandom_range(0, nc));
      end
      no_idle = 0;

      req_tvalid <= 1'b0;
      while (sums_pending.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);

      $display("covered %0d input transfers and %0d result transfers, %0d saturated sums,",
               items_sent, sums_seen, windows_sat);
      $display("extreme products, clamped registers, 16 kernels, a long receiver stall");
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/c2d_pkg.sv
rtl/c2d_ram.sv
rtl/c2d_datapath.sv
rtl/c2d_ctrl.sv
rtl/conv2d_forward_mac.sv
test/tb_top.sv
